/* hw/rtl/ppdms_pkg.sv */
// Package for the proportional position loop: register map, configuration
// struct, status codes and fixed-point constants.
// No dependencies.
`default_nettype none

package ppdms_pkg;

  // APB register map (byte address = 4 * index)
  localparam int unsigned PADDR_W = 5;
  localparam logic [2:0] REG_LOOP_ENABLE = 3'd0;
  localparam logic [2:0] REG_DIR_NEG     = 3'd1;
  localparam logic [2:0] REG_BASE_LEN    = 3'd2;
  localparam logic [2:0] REG_LEN_MIN     = 3'd3;
  localparam logic [2:0] REG_LEN_MAX     = 3'd4;
  localparam logic [2:0] REG_LEN_PER_CNT = 3'd5;
  localparam logic [2:0] REG_RPM_GAIN    = 3'd6;
  localparam logic [2:0] REG_INV_RATIO   = 3'd7;

  // Configuration as seen by the datapath (signed fields stored as raw bits)
  typedef struct packed {
    logic        loop_enable;
    logic        direction_negative;
    logic [23:0] len_offset;
    logic [23:0] length_min;
    logic [23:0] length_max;
    logic [31:0] length_per_count;
    logic [23:0] rpm_gain;
    logic [16:0] inverse_ratio;
  } cfg_t;

  // Motor state codes
  localparam logic [1:0] MS_NORMAL   = 2'd0;
  localparam logic [1:0] MS_LOADED   = 2'd1;
  localparam logic [1:0] MS_ERROR    = 2'd2;
  localparam logic [1:0] MS_OBSTACLE = 2'd3;

  // Loop status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_LIMITED   = 3'd1,
    ST_DISABLED  = 3'd2,
    ST_MOTOR_ERR = 3'd3,
    ST_OBSTACLE  = 3'd4,
    ST_LOADED    = 3'd5
  } status_e;

  // Loop constants (lengths in 1/256 mm, speeds in rpm)
  localparam int unsigned DEADBAND_TICKS = 512;
  localparam int unsigned RAMP_TICKS     = 1280;
  localparam int unsigned FLOOR_RPM      = 300;
  localparam int unsigned MAX_ROTOR_RPM  = 2800;

  // Datapath widths
  localparam int unsigned MAG_W   = 25;               // |error| after deadband
  localparam int unsigned RAW_W   = 24 + MAG_W;        // gain * magnitude, 2^-24 rpm
  localparam int unsigned RAMP_W  = $clog2(RAMP_TICKS + 1);
  localparam int unsigned MIN_W   = ($clog2(FLOOR_RPM + 1) > 0) ?
                                    $clog2(FLOOR_RPM + 1) : 1;
  localparam int unsigned X_W     = MIN_W + RAMP_W;    // FLOOR_RPM * ramp magnitude
  localparam int unsigned RAWLO_W = 24 + RAMP_W;       // raw inside the ramp
  localparam int unsigned THR_W   = RAWLO_W + 1 + RAMP_W;
  localparam int unsigned WHOLE_W = $clog2(MAX_ROTOR_RPM + 1);

  // Reciprocal of the ramp length, Q0.32, rounded up
  localparam longint unsigned RECIP = ((64'd1 << 32) + RAMP_TICKS - 1) / RAMP_TICKS;
  localparam int unsigned RECIP_W = $clog2(RECIP + 1);
  localparam int unsigned XR_W    = X_W + RECIP_W;

endpackage

`default_nettype wire

/* hw/rtl/ppdms_regs.sv */
// APB configuration registers of the position loop.
// Depends on ppdms_pkg for the register map and the cfg_t struct.
`default_nettype none

module ppdms_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ppdms_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready,
  output ppdms_pkg::cfg_t                   cfg_o
);

  ppdms_pkg::cfg_t cfg_q;
  logic [2:0]      idx;
  logic            wr_en;

  assign idx    = paddr[ppdms_pkg::PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.loop_enable        <= 1'b0;
      cfg_q.direction_negative <= 1'b0;
      cfg_q.len_offset         <= '0;
      cfg_q.length_min         <= '0;
      cfg_q.length_max         <= 24'h7F_FFFF;
      cfg_q.length_per_count   <= '0;
      cfg_q.rpm_gain           <= '0;
      cfg_q.inverse_ratio      <= 17'h1_0000;
    end else if (wr_en) begin
      unique case (idx)
        ppdms_pkg::REG_LOOP_ENABLE: cfg_q.loop_enable        <= pwdata[0];
        ppdms_pkg::REG_DIR_NEG:     cfg_q.direction_negative <= pwdata[0];
        ppdms_pkg::REG_BASE_LEN:    cfg_q.len_offset         <= pwdata[23:0];
        ppdms_pkg::REG_LEN_MIN:     cfg_q.length_min         <= pwdata[23:0];
        ppdms_pkg::REG_LEN_MAX:     cfg_q.length_max         <= pwdata[23:0];
        ppdms_pkg::REG_LEN_PER_CNT: cfg_q.length_per_count   <= pwdata;
        ppdms_pkg::REG_RPM_GAIN:    cfg_q.rpm_gain           <= pwdata[23:0];
        ppdms_pkg::REG_INV_RATIO:   cfg_q.inverse_ratio      <= pwdata[16:0];
      endcase
    end
  end

  // Read mux, signed lengths sign-extended
  always_comb begin
    unique case (idx)
      ppdms_pkg::REG_LOOP_ENABLE: prdata = {31'd0, cfg_q.loop_enable};
      ppdms_pkg::REG_DIR_NEG:     prdata = {31'd0, cfg_q.direction_negative};
      ppdms_pkg::REG_BASE_LEN:    prdata = {{8{cfg_q.len_offset[23]}}, cfg_q.len_offset};
      ppdms_pkg::REG_LEN_MIN:     prdata = {{8{cfg_q.length_min[23]}}, cfg_q.length_min};
      ppdms_pkg::REG_LEN_MAX:     prdata = {{8{cfg_q.length_max[23]}}, cfg_q.length_max};
      ppdms_pkg::REG_LEN_PER_CNT: prdata = cfg_q.length_per_count;
      ppdms_pkg::REG_RPM_GAIN:    prdata = {8'd0, cfg_q.rpm_gain};
      ppdms_pkg::REG_INV_RATIO:   prdata = {15'd0, cfg_q.inverse_ratio};
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/position_p_loop_deadband_min_speed.sv */
// Proportional position loop with deadband and minimum-speed assist, one side.
// An accepted input beat passes through the stage registers in turn to its result beat.
// Throughput: one beat per cycle unless the output stalls; each stage has its
// own valid bit, so a stalled output holds only the stages behind it that are full.
// Reset clears all stage valid bits and loads the register reset values.
// Depends on ppdms_pkg and ppdms_regs.
`default_nettype none

module position_p_loop_deadband_min_speed (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // APB configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ppdms_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  // Input channel
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [31:0]            encoder_total_i,
  input  wire logic signed [23:0]            target_length_i,
  input  wire logic        [1:0]             motor_state_i,
  // Output channel
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [12:0]                 rotor_speed_set_o,
  output logic signed [16:0]                 shaft_speed_target_o,
  output logic signed [23:0]                 current_length_o,
  output logic signed [23:0]                 clamped_target_o,
  output logic signed [24:0]                 length_error_o,
  output logic        [2:0]                  loop_status_o
);

  localparam int unsigned NumStg = 7;
  localparam int unsigned MagW   = ppdms_pkg::MAG_W;
  localparam int unsigned RawW   = ppdms_pkg::RAW_W;
  localparam int unsigned RampW  = ppdms_pkg::RAMP_W;
  localparam int unsigned MinW   = ppdms_pkg::MIN_W;
  localparam int unsigned XW     = ppdms_pkg::X_W;
  localparam int unsigned RawLoW = ppdms_pkg::RAWLO_W;
  localparam int unsigned ThrW   = ppdms_pkg::THR_W;
  localparam int unsigned WholeW = ppdms_pkg::WHOLE_W;
  localparam int unsigned XrW    = ppdms_pkg::XR_W;

  localparam logic [RawW-1:0] MinFull = RawW'(ppdms_pkg::FLOOR_RPM) << 24;

  ppdms_pkg::cfg_t cfg;

  ppdms_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------------------------------------------------------------------
  // Pipeline control: stage k advances when empty or when stage k+1 advances
  // ---------------------------------------------------------------------------
  logic [NumStg-1:0] vld_q;
  logic [NumStg-1:0] adv;

  always_comb begin
    adv[NumStg-1] = !vld_q[NumStg-1] || !out_stall_i;
    for (int k = NumStg - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[NumStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NumStg; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: |count| * length_per_count, target clamp
  // ---------------------------------------------------------------------------
  logic [31:0]        cnt_mag;
  logic signed [23:0] len_min, len_max, lim_d;

  logic [63:0]        s1_prod_q;
  logic               s1_neg_q;
  logic signed [23:0] s1_lim_q;
  logic               s1_limited_q;
  logic [1:0]         s1_ms_q;

  assign cnt_mag = encoder_total_i[31] ? (~encoder_total_i + 32'd1) : encoder_total_i;
  assign len_min = $signed(cfg.length_min);
  assign len_max = $signed(cfg.length_max);

  always_comb begin
    priority if (target_length_i < len_min) lim_d = len_min;
    else if (target_length_i > len_max)     lim_d = len_max;
    else                                    lim_d = target_length_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_prod_q    <= 64'(cnt_mag) * 64'(cfg.length_per_count);
      s1_neg_q     <= encoder_total_i[31] ^ cfg.direction_negative;
      s1_lim_q     <= lim_d;
      s1_limited_q <= (lim_d != target_length_i);
      s1_ms_q      <= motor_state_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: current length = sat24(base +/- delta), status decode
  // ---------------------------------------------------------------------------
  logic signed [41:0] base_ext, dlt_ext, cur_sum;
  logic signed [23:0] cur_d;
  ppdms_pkg::status_e st_d;
  logic               run_d;

  logic signed [23:0] s2_cur_q, s2_lim_q;
  ppdms_pkg::status_e s2_st_q;
  logic               s2_run_q;

  assign base_ext = $signed({{18{cfg.len_offset[23]}}, cfg.len_offset});
  assign dlt_ext  = $signed({2'b00, s1_prod_q[63:24]});
  assign cur_sum  = s1_neg_q ? (base_ext - dlt_ext) : (base_ext + dlt_ext);

  // saturate when the upper bits are not a sign extension
  always_comb begin
    if (cur_sum[41:23] == '0 || cur_sum[41:23] == '1) begin
      cur_d = cur_sum[23:0];
    end else begin
      cur_d = cur_sum[41] ? 24'sh80_0000 : 24'sh7F_FFFF;
    end
  end

  always_comb begin
    run_d = 1'b0;
    priority if (!cfg.loop_enable) begin
      st_d = ppdms_pkg::ST_DISABLED;
    end else if (s1_ms_q == ppdms_pkg::MS_ERROR) begin
      st_d = ppdms_pkg::ST_MOTOR_ERR;
    end else if (s1_ms_q == ppdms_pkg::MS_OBSTACLE) begin
      st_d = ppdms_pkg::ST_OBSTACLE;
    end else begin
      run_d = 1'b1;
      priority if (s1_limited_q)                 st_d = ppdms_pkg::ST_LIMITED;
      else if (s1_ms_q == ppdms_pkg::MS_LOADED)  st_d = ppdms_pkg::ST_LOADED;
      else                                       st_d = ppdms_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_cur_q <= cur_d;
      s2_lim_q <= s1_lim_q;
      s2_st_q  <= st_d;
      s2_run_q <= run_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: error and deadband
  // ---------------------------------------------------------------------------
  logic signed [24:0] err_d;
  logic [MagW-1:0]    err_abs;

  logic signed [23:0] s3_cur_q, s3_lim_q;
  logic signed [24:0] s3_err_q;
  logic [MagW-1:0]    s3_mag_q;
  ppdms_pkg::status_e s3_st_q;
  logic               s3_run_q;

  assign err_d   = {s2_lim_q[23], s2_lim_q} - {s2_cur_q[23], s2_cur_q};
  assign err_abs = err_d[24] ? MagW'(~err_d + 25'sd1) : MagW'(err_d);

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s3_cur_q <= s2_cur_q;
      s3_lim_q <= s2_lim_q;
      s3_err_q <= err_d;
      s3_mag_q <= (err_abs > MagW'(ppdms_pkg::DEADBAND_TICKS)) ?
                  (err_abs - MagW'(ppdms_pkg::DEADBAND_TICKS)) : '0;
      s3_st_q  <= s2_st_q;
      s3_run_q <= s2_run_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: raw speed = gain * |ctrl|, assist numerator
  // ---------------------------------------------------------------------------
  logic signed [23:0] s4_cur_q, s4_lim_q;
  logic signed [24:0] s4_err_q;
  logic [RawW-1:0]    s4_raw_q;
  logic [XW-1:0]      s4_x_q;
  logic               s4_full_q;
  logic               s4_neg_q;
  ppdms_pkg::status_e s4_st_q;
  logic               s4_run_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s4_cur_q  <= s3_cur_q;
      s4_lim_q  <= s3_lim_q;
      s4_err_q  <= s3_err_q;
      s4_raw_q  <= RawW'(cfg.rpm_gain) * RawW'(s3_mag_q);
      s4_x_q    <= XW'(ppdms_pkg::FLOOR_RPM) * XW'(s3_mag_q[RampW-1:0]);
      s4_full_q <= (s3_mag_q >= MagW'(ppdms_pkg::RAMP_TICKS));
      s4_neg_q  <= s3_err_q[24] ^ cfg.direction_negative;
      s4_st_q   <= s3_st_q;
      s4_run_q  <= s3_run_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: assist threshold (raw+1)*ramp and quotient x/ramp
  // ---------------------------------------------------------------------------
  logic [XrW-1:0]     xr_prod;

  logic signed [23:0] s5_cur_q, s5_lim_q;
  logic signed [24:0] s5_err_q;
  logic [ThrW-1:0]    s5_thr_q;
  logic [XW-1:0]      s5_x_q;
  logic [MinW-1:0]    s5_q_q;
  logic [RawW-25:0]   s5_rwhole_q;
  logic               s5_rnz_q;
  logic               s5_ltmin_q;
  logic               s5_full_q;
  logic               s5_neg_q;
  ppdms_pkg::status_e s5_st_q;
  logic               s5_run_q;

  assign xr_prod = XrW'(s4_x_q) * XrW'(ppdms_pkg::RECIP);

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      s5_cur_q    <= s4_cur_q;
      s5_lim_q    <= s4_lim_q;
      s5_err_q    <= s4_err_q;
      s5_thr_q    <= (ThrW'(s4_raw_q[RawLoW-1:0]) + ThrW'(1)) *
                     ThrW'(ppdms_pkg::RAMP_TICKS);
      s5_x_q      <= s4_x_q;
      s5_q_q      <= xr_prod[32 +: MinW];
      s5_rwhole_q <= s4_raw_q[RawW-1:24];
      s5_rnz_q    <= (s4_raw_q != '0);
      s5_ltmin_q  <= (s4_raw_q < MinFull);
      s5_full_q   <= s4_full_q;
      s5_neg_q    <= s4_neg_q;
      s5_st_q     <= s4_st_q;
      s5_run_q    <= s4_run_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: apply assist, cap, gate on run
  // ---------------------------------------------------------------------------
  logic                use_assist;
  logic [RawW-24-1:0]  spd_sel;
  logic [WholeW-1:0]   whole_d;

  logic signed [23:0]  s6_cur_q, s6_lim_q;
  logic signed [24:0]  s6_err_q;
  logic [WholeW-1:0]   s6_whole_q;
  logic                s6_neg_q;
  ppdms_pkg::status_e  s6_st_q;

  always_comb begin
    // inside the ramp: raw < floor(MIN*2^24*mag/ramp) <=> (raw+1)*ramp <= MIN*mag*2^24
    if (s5_full_q) begin
      use_assist = s5_ltmin_q;
      spd_sel    = s5_ltmin_q ? (RawW-24)'(ppdms_pkg::FLOOR_RPM) : s5_rwhole_q;
    end else begin
      use_assist = (s5_thr_q <= (ThrW'(s5_x_q) << 24));
      spd_sel    = use_assist ? (RawW-24)'(s5_q_q) : s5_rwhole_q;
    end
    if (!s5_run_q || !s5_rnz_q) begin
      whole_d = '0;
    end else if (spd_sel > (RawW-24)'(ppdms_pkg::MAX_ROTOR_RPM)) begin
      whole_d = WholeW'(ppdms_pkg::MAX_ROTOR_RPM);
    end else begin
      whole_d = spd_sel[WholeW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      s6_cur_q   <= s5_cur_q;
      s6_lim_q   <= s5_lim_q;
      s6_err_q   <= s5_err_q;
      s6_whole_q <= whole_d;
      s6_neg_q   <= s5_neg_q;
      s6_st_q    <= s5_st_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7 (output register): shaft speed and signed results
  // ---------------------------------------------------------------------------
  logic [16:0]              inv_c;
  logic [WholeW+17-1:0]     shaft_prod;
  logic [16:0]              shaft_mag;
  logic [12:0]              rotor_mag;

  assign inv_c      = (cfg.inverse_ratio[16] && (cfg.inverse_ratio[15:0] != '0)) ?
                      17'h1_0000 : cfg.inverse_ratio;
  assign shaft_prod = (WholeW+17)'(s6_whole_q) * (WholeW+17)'(inv_c);
  assign shaft_mag  = 17'(shaft_prod >> 12);
  assign rotor_mag  = 13'(s6_whole_q);

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      rotor_speed_set_o    <= s6_neg_q ? $signed(-rotor_mag) : $signed(rotor_mag);
      shaft_speed_target_o <= s6_neg_q ? $signed(-shaft_mag) : $signed(shaft_mag);
      current_length_o     <= s6_cur_q;
      clamped_target_o     <= s6_lim_q;
      length_error_o       <= s6_err_q;
      loop_status_o        <= s6_st_q;
    end
  end

`ifndef SYNTHESIS
  // Stopped loop must command zero speed
  a_stop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (loop_status_o == ppdms_pkg::ST_DISABLED ||
                    loop_status_o == ppdms_pkg::ST_MOTOR_ERR ||
                    loop_status_o == ppdms_pkg::ST_OBSTACLE)
    |-> rotor_speed_set_o == 13'sd0 && shaft_speed_target_o == 17'sd0)
    else $error("nonzero speed while loop stopped");

  // Speed stays within the rotor limit
  a_rotor_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> rotor_speed_set_o <= $signed(13'(ppdms_pkg::MAX_ROTOR_RPM)) &&
                    rotor_speed_set_o >= -$signed(13'(ppdms_pkg::MAX_ROTOR_RPM)))
    else $error("rotor speed beyond limit");

  // Shaft speed zero with rotor zero, and never opposite in sign
  a_shaft_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> shaft_speed_target_o == 17'sd0 ||
                    (rotor_speed_set_o != 13'sd0 &&
                     shaft_speed_target_o[16] == rotor_speed_set_o[12]))
    else $error("shaft speed inconsistent with rotor speed");

  // Input is never stalled while the first stage is empty
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0] |-> !in_stall_o)
    else $error("input stalled with empty first stage");
`endif

endmodule

`default_nettype wire
